>>> hw/rtl/klx_pkg.sv
// Shared types, constants and word tables for the keyword lexer.
package klx_pkg;

    localparam int MAX_TOKEN   = 60;
    localparam int LINE_BITS   = 20;
    localparam int LEN_W       = $clog2(MAX_TOKEN + 1);
    localparam int ADDR_W      = $clog2(MAX_TOKEN);
    localparam int NUM_WORDS   = 10;
    localparam int WORD_MAX    = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_SEP     = 3'd0,
        KIND_OP      = 3'd1,
        KIND_INT     = 3'd2,
        KIND_KEYWORD = 3'd3,
        KIND_CMP     = 3'd4,
        KIND_IDENT   = 3'd5,
        KIND_STRING  = 3'd6,
        KIND_END     = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        CLS_SEP,
        CLS_OP,
        CLS_QUOTE,
        CLS_DIGIT,
        CLS_LETTER,
        CLS_UNDER,
        CLS_NEWLINE,
        CLS_OTHER
    } cls_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_WORD,
        MODE_STRING
    } mode_t;

    typedef enum logic [3:0] {
        BK_FETCH,
        BK_CLOSE,
        BK_RD,
        BK_EMIT,
        BK_CODED,
        BK_CLASSIFY,
        BK_SINGLE,
        BK_FIN,
        BK_END
    } back_state_t;

    // Which close is in progress decides where the sequencer goes afterwards.
    typedef enum logic [1:0] {
        PH_PRE,
        PH_QUOTE,
        PH_FIN
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        cls_t       cls;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Text of keyword 0 (the block-begin keyword), as ASCII codes.
    localparam logic [8*WORD_MAX-1:0] KW_BEGIN_TXT = 104'h6b695f6b6f72746563686f6368;

    localparam logic [8*WORD_MAX-1:0] WORD_TXT [NUM_WORDS] = '{
        KW_BEGIN_TXT, "exit", "int", "jodi", "zotokhhon", "likh",
        "soman", "osoman", "chuto", "boro"
    };
    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd13, 4'd4, 4'd3, 4'd4, 4'd9, 4'd4, 4'd5, 4'd6, 4'd5, 4'd4
    };
    localparam kind_t WORD_KIND [NUM_WORDS] = '{
        KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD, KIND_KEYWORD,
        KIND_KEYWORD, KIND_CMP, KIND_CMP, KIND_CMP, KIND_CMP
    };
    localparam logic [2:0] WORD_CODE [NUM_WORDS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3
    };

    // True when word k has character c at position p.
    function automatic logic word_char_hit(input int k, input logic [LEN_W-1:0] p,
                                           input logic [7:0] c);
        logic [8*WORD_MAX-1:0] txt;
        int                    l;
        int                    pi;
        logic                  hit;
        txt = WORD_TXT[k];
        l   = int'(WORD_LEN[k]);
        pi  = int'(p);
        hit = 1'b0;
        if (pi < l) begin
            hit = (txt[8*(l-1-pi) +: 8] == c);
        end
        return hit;
    endfunction

endpackage

>>> hw/rtl/klx_ram.sv
// Generic single-port-write, registered-read RAM.
module klx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/klx_front.sv
// Front end: accepts source bytes and classifies them into queue commands.
module klx_front (
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    ch,
    input  logic          final_byte,
    input  klx_pkg::q_status_t q_status,
    output logic          push,
    output klx_pkg::cmd_t push_cmd
);
    import klx_pkg::*;

    cls_t cls;

    // Character class decode.
    always_comb
    begin
        cls = CLS_OTHER;
        if (ch == 8'h3B || ch == 8'h2C || ch == 8'h28 || ch == 8'h29 ||
            ch == 8'h7B || ch == 8'h7D)
        begin
            cls = CLS_SEP;
        end
        else if (ch == 8'h3D || ch == 8'h2B || ch == 8'h2D || ch == 8'h2A ||
                 ch == 8'h2F || ch == 8'h25)
        begin
            cls = CLS_OP;
        end
        else if (ch == 8'h22)
        begin
            cls = CLS_QUOTE;
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            cls = CLS_DIGIT;
        end
        else if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A))
        begin
            cls = CLS_LETTER;
        end
        else if (ch == 8'h5F)
        begin
            cls = CLS_UNDER;
        end
        else if (ch == 8'h0A)
        begin
            cls = CLS_NEWLINE;
        end
    end

    // A beat is taken whenever the queue has room.
    assign in_ready     = !q_status.full;
    assign push         = in_valid && !q_status.full;
    assign push_cmd.ch  = ch;
    assign push_cmd.cls = cls;
    assign push_cmd.fin = final_byte;

endmodule

>>> hw/rtl/klx_queue.sv
// Short command queue between the front end and the token sequencer.
module klx_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  klx_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output klx_pkg::cmd_t      head,
    output klx_pkg::q_status_t status
);
    import klx_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    assign head         = entry_reg[rptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

>>> hw/rtl/klx_back.sv
// Token sequencer: keeps scan state and token buffer, emits result beats.
module klx_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  klx_pkg::cmd_t                  head,
    input  klx_pkg::q_status_t             q_status,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     kind,
    output logic [2:0]                     word_code,
    output logic [7:0]                     text_char,
    output logic [5:0]                     char_pos,
    output logic [klx_pkg::LINE_BITS-1:0]  line,
    output logic                           truncated,
    output logic                           unterminated,
    output logic                           last
);
    import klx_pkg::*;

    back_state_t           state_reg, state_next;
    phase_t                phase_reg, phase_next;
    mode_t                 mode_reg, mode_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  ovf_reg, ovf_next;
    logic [NUM_WORDS-1:0]  cand_reg, cand_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [LEN_W-1:0]      idx_reg, idx_next;
    kind_t                 tkind_reg, tkind_next;
    logic                  unterm_reg, unterm_next;

    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            kind_reg, kind_next;
    logic [2:0]            code_reg, code_next;
    logic [7:0]            text_reg, text_next;
    logic [5:0]            pos_reg, pos_next;
    logic [LINE_BITS-1:0]  oline_reg, oline_next;
    logic                  trunc_reg, trunc_next;
    logic                  unt_reg, unt_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic                  app_en;
    logic [7:0]            app_ch;
    logic                  clr_en;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [7:0]            ram_rdata;
    logic                  match;
    kind_t                 match_kind;
    logic [2:0]            match_code;
    logic                  emit_last;
    phase_t                after_phase;
    back_state_t           after_close;

    klx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TOKEN)
    ) u_text (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (app_ch),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Keyword match over the surviving candidates.
    always_comb
    begin
        match      = 1'b0;
        match_kind = KIND_IDENT;
        match_code = 3'd0;
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            if (cand_reg[k] && len_reg == LEN_W'(WORD_LEN[k]) && !ovf_reg)
            begin
                match      = 1'b1;
                match_kind = WORD_KIND[k];
                match_code = WORD_CODE[k];
            end
        end
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign emit_last   = (len_reg == '0) || (idx_reg + 1'b1 == len_reg);
    assign after_phase = phase_reg;

    // Where a finished close hands over.
    always_comb
    begin
        unique case (after_phase)
            PH_PRE:   after_close = BK_CLASSIFY;
            PH_QUOTE: after_close = BK_FIN;
            PH_FIN:   after_close = BK_END;
            default:  after_close = BK_FETCH;
        endcase
    end

    // Sequencer next state and outputs.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        cand_next      = cand_reg;
        line_next      = line_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        tkind_next     = tkind_reg;
        unterm_next    = unterm_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        code_next      = code_reg;
        text_next      = text_reg;
        pos_next       = pos_reg;
        oline_next     = oline_reg;
        trunc_next     = trunc_reg;
        unt_next       = unt_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        app_en         = 1'b0;
        app_ch         = cmd_reg.ch;
        clr_en         = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = len_reg[ADDR_W-1:0];

        unique case (state_reg)
            BK_FETCH:
            begin
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    app_ch   = head.ch;
                    if ((mode_reg == MODE_STRING && head.cls != CLS_QUOTE) ||
                        (mode_reg == MODE_NUMBER && head.cls == CLS_DIGIT) ||
                        (mode_reg == MODE_WORD &&
                         (head.cls == CLS_LETTER || head.cls == CLS_UNDER)))
                    begin
                        app_en     = 1'b1;
                        state_next = BK_FIN;
                    end
                    else if (mode_reg == MODE_STRING)
                    begin
                        phase_next = PH_QUOTE;
                        state_next = BK_CLOSE;
                    end
                    else
                    begin
                        phase_next = PH_PRE;
                        state_next = BK_CLOSE;
                    end
                end
            end
            BK_CLOSE:
            begin
                idx_next    = '0;
                unterm_next = 1'b0;
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        clr_en     = 1'b1;
                        state_next = after_close;
                    end
                    MODE_NUMBER:
                    begin
                        tkind_next = KIND_INT;
                        state_next = BK_RD;
                    end
                    MODE_WORD:
                    begin
                        tkind_next = match ? match_kind : KIND_IDENT;
                        state_next = match ? BK_CODED : BK_RD;
                    end
                    MODE_STRING:
                    begin
                        tkind_next  = KIND_STRING;
                        unterm_next = (phase_reg == PH_FIN);
                        state_next  = BK_RD;
                    end
                    default:
                    begin
                        state_next = BK_FETCH;
                    end
                endcase
            end
            BK_RD:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = tkind_reg;
                    code_next      = 3'd0;
                    text_next      = (len_reg == '0) ? 8'd0 : ram_rdata;
                    pos_next       = 6'(idx_reg);
                    oline_next     = line_reg;
                    trunc_next     = ovf_reg;
                    unt_next       = unterm_reg;
                    last_next      = emit_last;
                    if (emit_last)
                    begin
                        clr_en     = 1'b1;
                        state_next = after_close;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = BK_RD;
                    end
                end
            end
            BK_CODED:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = tkind_reg;
                    code_next      = match_code;
                    text_next      = 8'd0;
                    pos_next       = 6'd0;
                    oline_next     = line_reg;
                    trunc_next     = 1'b0;
                    unt_next       = 1'b0;
                    last_next      = 1'b1;
                    clr_en         = 1'b1;
                    state_next     = after_close;
                end
            end
            BK_CLASSIFY:
            begin
                state_next = BK_FIN;
                unique case (cmd_reg.cls)
                    CLS_SEP:
                    begin
                        tkind_next = KIND_SEP;
                        state_next = BK_SINGLE;
                    end
                    CLS_OP:
                    begin
                        tkind_next = KIND_OP;
                        state_next = BK_SINGLE;
                    end
                    CLS_QUOTE:
                    begin
                        mode_next = MODE_STRING;
                    end
                    CLS_DIGIT:
                    begin
                        mode_next = MODE_NUMBER;
                        app_en    = 1'b1;
                    end
                    CLS_LETTER:
                    begin
                        mode_next = MODE_WORD;
                        app_en    = 1'b1;
                    end
                    CLS_NEWLINE:
                    begin
                        if (line_reg != '1)
                        begin
                            line_next = line_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = BK_FIN;
                    end
                endcase
            end
            BK_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = tkind_reg;
                    code_next      = 3'd0;
                    text_next      = cmd_reg.ch;
                    pos_next       = 6'd0;
                    oline_next     = line_reg;
                    trunc_next     = 1'b0;
                    unt_next       = 1'b0;
                    last_next      = 1'b1;
                    state_next     = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (cmd_reg.fin)
                begin
                    phase_next = PH_FIN;
                    state_next = BK_CLOSE;
                end
                else
                begin
                    state_next = BK_FETCH;
                end
            end
            BK_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_END;
                    code_next      = 3'd0;
                    text_next      = 8'd0;
                    pos_next       = 6'd0;
                    oline_next     = line_reg;
                    trunc_next     = 1'b0;
                    unt_next       = 1'b0;
                    last_next      = 1'b1;
                    line_next      = LINE_BITS'(1);
                    state_next     = BK_FETCH;
                end
            end
            default:
            begin
                state_next = BK_FETCH;
            end
        endcase

        // Append a character to the token buffer and narrow the candidates.
        if (app_en)
        begin
            if (len_reg < LEN_W'(MAX_TOKEN))
            begin
                ram_we   = 1'b1;
                len_next = len_reg + 1'b1;
                for (int k = 0; k < NUM_WORDS; k++)
                begin
                    cand_next[k] = cand_reg[k] && word_char_hit(k, len_reg, app_ch);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        // Drop the finished token.
        if (clr_en)
        begin
            mode_next = MODE_IDLE;
            len_next  = '0;
            ovf_next  = 1'b0;
            cand_next = '1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_FETCH;
            phase_reg     <= PH_PRE;
            mode_reg      <= MODE_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            cand_reg      <= '1;
            line_reg      <= LINE_BITS'(1);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            cand_reg      <= cand_next;
            line_reg      <= line_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        tkind_reg  <= tkind_next;
        unterm_reg <= unterm_next;
        kind_reg   <= kind_next;
        code_reg   <= code_next;
        text_reg   <= text_next;
        pos_reg    <= pos_next;
        oline_reg  <= oline_next;
        trunc_reg  <= trunc_next;
        unt_reg    <= unt_next;
        last_reg   <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign word_code    = code_reg;
    assign text_char    = text_reg;
    assign char_pos     = pos_reg;
    assign line         = oline_reg;
    assign truncated    = trunc_reg;
    assign unterminated = unt_reg;
    assign last         = last_reg;

endmodule

>>> hw/rtl/keyword_lexer_core.sv
// Keyword lexer: byte-serial tokenizer for a small keyword language.
//
// Source bytes arrive on the input channel (in_valid/in_ready, ch, final_byte);
// one beat carries one byte, and final_byte marks the last byte of a text.
// Tokens leave on the output channel (out_valid/out_ready) one beat per token
// character, with kind, word_code, char_pos, line and the truncated,
// unterminated and last flags. Coded keywords and comparators, separators,
// operators and the end marker take one beat each.
// The front end classifies each byte into a two-entry command queue; the
// token sequencer behind it works one command at a time. A byte that only
// extends a token passes the sequencer's fetch and finish states; closing a
// text token emits each character after a registered read of the token buffer.
// When the receiver holds out_ready low, the sequencer waits with its beat;
// the queue fills and in_ready then falls until room frees up.
// Reset empties the queue, returns the scanner to idle and sets the line
// count to one. After an end marker the line count is one again.
module keyword_lexer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    ch,
    input  logic                          final_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    kind,
    output logic [2:0]                    word_code,
    output logic [7:0]                    text_char,
    output logic [5:0]                    char_pos,
    output logic [klx_pkg::LINE_BITS-1:0] line,
    output logic                          truncated,
    output logic                          unterminated,
    output logic                          last
);
    import klx_pkg::*;

    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;

    klx_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .final_byte (final_byte),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    klx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    klx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .word_code    (word_code),
        .text_char    (text_char),
        .char_pos     (char_pos),
        .line         (line),
        .truncated    (truncated),
        .unterminated (unterminated),
        .last         (last)
    );

    // The sequencer never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
        else $error("pop from empty command queue");

    // Coded tokens and the end marker are single beats with no text.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_KEYWORD || kind == KIND_CMP || kind == KIND_END)
        |-> last && text_char == 8'd0 && char_pos == 6'd0)
        else $error("coded token beat carries text or is not last");

    // Only text tokens span several beats.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_pos != 6'd0
        |-> (kind == KIND_INT || kind == KIND_IDENT || kind == KIND_STRING))
        else $error("multi-beat token of a single-beat kind");

endmodule
